// File: rtl/core/sdem_pkg.sv
package sdem_pkg;

  typedef struct packed {
    logic [7:0] left_x;
    logic [7:0] left_y;
    logic [7:0] right_x;
    logic [7:0] right_y;
  } sample_t;

  typedef struct packed {
    logic signed [14:0] steering;
    logic               throttle_active;
    logic [12:0]        throttle;
    logic               brake_active;
    logic [12:0]        brake;
    logic               camera_active;
    logic signed [15:0] camera;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_MUL, ST_SUM, ST_DIV_START, ST_DIV_RUN, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    DZ_CAM_NEG, DZ_CAM_POS, DZ_RLEFT, DZ_UP, DZ_DOWN
  } dz_sel_t;

  localparam int DivW = 48;

  typedef struct packed {
    logic load;
    logic div_start;
    logic dz_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic dz_done;
  } status_t;

  localparam logic [2:0] REG_EXPO   = 3'd0;
  localparam logic [2:0] REG_EDGE   = 3'd1;
  localparam logic [2:0] REG_CENTER = 3'd2;
  localparam logic [2:0] REG_OUTER  = 3'd3;
  localparam logic [2:0] REG_INNER  = 3'd4;
  localparam logic [2:0] REG_SWAP   = 3'd5;
  localparam logic [2:0] REG_CAM    = 3'd6;

  // divides by 30 and 31 done by reciprocal multiplication
  function automatic logic [12:0] throttle_curve(input logic [6:0] a);
    logic [13:0] y;
    logic [12:0] t;
    begin
      if (a >= 7'd95) begin
        y = 14'(a - 7'd95) * 14'd164;
        t = 13'd3932 + 13'(y >> 5);
        if (t > 13'd4096) t = 13'd4096;
      end else if (a >= 7'd64) begin
        y = 14'(a - 7'd64) * 14'd204;
        t = 13'd3727 + 13'((28'(y) * 28'd8739) >> 18);
      end else if (a >= 7'd32) begin
        y = 14'(a - 7'd32) * 14'd409;
        t = 13'd3317 + 13'((28'(y) * 28'd16913) >> 19);
      end else begin
        y = 14'(a) * 14'd409;
        t = 13'd2908 + 13'((28'(y) * 28'd16913) >> 19);
      end
      return t;
    end
  endfunction

  // b * 4096 / 127 = 32b + 32b / 127
  function automatic logic [12:0] brake_curve(input logic [6:0] b);
    logic [11:0] y;
    begin
      y = {b, 5'd0};
      return 13'(y) + 13'(((22'(y) + 22'd1) * 22'd129) >> 14);
    end
  endfunction

  // round(c * 24576 / 127) = 193c + (65c + 63) / 127
  function automatic logic [14:0] camera_curve(input logic [6:0] c);
    logic [13:0] y;
    begin
      y = 14'(c) * 14'd65 + 14'd64;
      return 15'(c) * 15'd193 + 15'((21'(y) * 21'd129) >> 14);
    end
  endfunction

endpackage

// File: rtl/core/sdem_divider.sv
module sdem_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [sdem_pkg::DivW-1:0] dividend,
  input  logic [sdem_pkg::DivW-1:0] divisor,
  output logic                      busy,
  output logic [sdem_pkg::DivW-1:0] quotient
);
  import sdem_pkg::*;

  localparam int CntW = $clog2(DivW + 1);

  logic [DivW-1:0] rem;
  logic [DivW-1:0] quo;
  logic [DivW-1:0] den;
  logic [CntW-1:0] cnt;
  logic [DivW:0]   trial;

  assign trial = {rem, quo[DivW-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CntW'(DivW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      den <= divisor;
    end else if (busy) begin
      if (!trial[DivW]) begin
        rem <= trial[DivW-1:0];
        quo <= {quo[DivW-2:0], 1'b1};
      end else begin
        rem <= {rem[DivW-2:0], quo[DivW-1]};
        quo <= {quo[DivW-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;
endmodule

// File: rtl/core/sdem_ctrl.sv
module sdem_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              out_valid,
  input  logic              out_stall,
  input  sdem_pkg::status_t status,
  output sdem_pkg::cmd_t    cmd
);
  import sdem_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_SUM;
      end
      ST_SUM: begin
        state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd.dz_step = !status.dz_done;
        if (!status.div_busy && status.dz_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// File: rtl/core/sdem_datapath.sv
module sdem_datapath #(
  parameter int STEER_FULL_SCALE = 8192
) (
  input  logic              clk,
  input  logic              rst,
  input  sdem_pkg::cmd_t    cmd,
  output sdem_pkg::status_t status,
  input  sdem_pkg::sample_t in_data,
  input  logic [6:0]        expo_percent,
  input  logic [6:0]        steer_edge,
  input  logic [6:0]        steer_center_zone,
  input  logic [6:0]        outer_zone,
  input  logic [6:0]        inner_zone,
  input  logic              swap_axes,
  input  logic              camera_enable,
  input  logic              out_stall,
  output logic              out_valid,
  output sdem_pkg::result_t out_data
);
  import sdem_pkg::*;

  sample_t         smp;
  logic            seen;
  logic [6:0]      dz_val [5];
  dz_sel_t         dz_idx;
  logic            dz_done;

  // deadzone: axes handled one at a time, each a small divide by range via restoring steps
  logic [7:0]      mag;
  logic [6:0]      range_w, v_w;
  logic [13:0]     prod;
  logic [6:0]      dz_res;
  logic [13:0]     r_acc;
  logic [6:0]      q_acc;
  logic [3:0]      bit_i;

  always_comb begin
    mag = '0;
    unique case (dz_idx)
      DZ_CAM_NEG: mag = (smp.left_y < 8'd128) ? 8'd128 - smp.left_y : 8'd0;
      DZ_CAM_POS: mag = (smp.left_y > 8'd128) ? smp.left_y - 8'd128 : 8'd0;
      DZ_RLEFT:   mag = (smp.right_x < 8'd128) ? 8'd128 - smp.right_x : 8'd0;
      DZ_UP:      mag = (smp.right_y < 8'd128) ? 8'd128 - smp.right_y : 8'd0;
      DZ_DOWN:    mag = (smp.right_y > 8'd128) ? smp.right_y - 8'd128 : 8'd0;
      default:    mag = '0;
    endcase
    range_w = outer_zone - inner_zone;
    v_w     = (mag - {1'b0, inner_zone} > {1'b0, range_w}) ? range_w
            : 7'(mag - {1'b0, inner_zone});
    prod    = 14'(v_w) * 14'd127;
  end

  logic dz_special, dz_zero, dz_full;
  assign dz_zero    = (mag == 8'd0) || (mag < {1'b0, inner_zone});
  assign dz_full    = outer_zone <= inner_zone;
  assign dz_special = dz_zero || dz_full;
  assign dz_res     = dz_zero ? 7'd0 : 7'd127;

  logic [14:0] r_try;
  assign r_try = {r_acc, prod[4'(13) - bit_i]} - {8'd0, range_w};

  always_ff @(posedge clk) begin
    if (rst) begin
      dz_idx  <= DZ_CAM_NEG;
      dz_done <= 1'b0;
      bit_i   <= '0;
      seen    <= 1'b0;
    end else if (cmd.load) begin
      dz_idx  <= DZ_CAM_NEG;
      dz_done <= 1'b0;
      bit_i   <= '0;
      r_acc   <= '0;
      q_acc   <= '0;
      if (in_data.right_x != 8'd0 || in_data.right_y != 8'd0) seen <= 1'b1;
    end else if (cmd.dz_step) begin
      if (dz_special) begin
        dz_val[dz_idx] <= dz_res;
        bit_i <= '0;
        r_acc <= '0;
        if (dz_idx == DZ_DOWN) dz_done <= 1'b1;
        else dz_idx <= dz_sel_t'(dz_idx + 3'd1);
      end else begin
        if (!r_try[14]) begin
          r_acc <= r_try[13:0];
          q_acc <= {q_acc[5:0], 1'b1};
        end else begin
          r_acc <= {r_acc[12:0], prod[4'(13) - bit_i]};
          q_acc <= {q_acc[5:0], 1'b0};
        end
        if (bit_i == 4'd13) begin
          dz_val[dz_idx] <= r_try[14] ? {q_acc[5:0], 1'b0} : {q_acc[5:0], 1'b1};
          bit_i <= '0;
          r_acc <= '0;
          if (dz_idx == DZ_DOWN) dz_done <= 1'b1;
          else dz_idx <= dz_sel_t'(dz_idx + 3'd1);
        end else begin
          bit_i <= bit_i + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) smp <= in_data;
  end

  // steering: products formed in pipelined registers (rr to hr, then pa/pb/dp, then num/den), then divided
  logic [7:0]       d_raw;
  logic             neg;
  logic [6:0]       d_cl, n_w, r_w, e_w;
  logic [DivW-1:0]  num, den, dividend, divisor, quotient;
  logic [13:0]      rr, nn, an, bn, hr;
  logic [27:0]      pa, pb, dp;
  logic             div_busy;
  logic             s_zero, s_full;
  logic [DivW-1:0]  fs_w;

  assign fs_w  = DivW'(STEER_FULL_SCALE);
  assign d_raw = (smp.left_x < 8'd128) ? 8'd128 - smp.left_x : smp.left_x - 8'd128;
  assign neg   = smp.left_x > 8'd128;
  assign d_cl  = (d_raw > {1'b0, steer_edge}) ? steer_edge : d_raw[6:0];
  assign n_w   = d_cl - steer_center_zone;
  assign r_w   = steer_edge - steer_center_zone;
  assign e_w   = (expo_percent > 7'd100) ? 7'd100 : expo_percent;

  always_ff @(posedge clk) begin
    rr     <= 14'(r_w) * 14'(r_w);
    nn     <= 14'(n_w) * 14'(n_w);
    an     <= 14'(7'd100 - e_w) * 14'(n_w);
    bn     <= 14'(e_w) * 14'(n_w);
    hr     <= 14'd100 * 14'(r_w);
    pa     <= 28'(an) * 28'(rr);
    pb     <= 28'(bn) * 28'(nn);
    dp     <= 28'(hr) * 28'(rr);
    num    <= DivW'(pa) + DivW'(pb);
    den    <= DivW'(dp);
    s_zero <= (d_raw == 8'd0) || (d_raw <= {1'b0, steer_center_zone});
    s_full <= steer_edge <= steer_center_zone;
  end

  assign dividend = 2 * fs_w * num + den;
  assign divisor  = 2 * den;

  sdem_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign status.div_busy = div_busy;
  assign status.dz_done  = dz_done;

  logic [DivW-1:0]     s_mag;
  logic signed [14:0]  steer;
  logic [6:0]          accel, brk;
  logic [14:0]         cam_m;
  result_t             res;

  always_comb begin
    if (s_zero)      s_mag = '0;
    else if (s_full) s_mag = fs_w;
    else             s_mag = (quotient > fs_w) ? fs_w : quotient;
    steer = neg ? -15'(s_mag) : 15'(s_mag);
    accel = seen ? (swap_axes ? dz_val[DZ_RLEFT] : dz_val[DZ_UP]) : 7'd0;
    brk   = seen ? dz_val[DZ_DOWN] : 7'd0;
    res.steering        = steer;
    res.throttle_active = accel != 7'd0;
    res.throttle        = (accel != 7'd0) ? throttle_curve(accel) : 13'd0;
    res.brake_active    = brk != 7'd0;
    res.brake           = (brk != 7'd0) ? brake_curve(brk) : 13'd0;
    res.camera_active   = 1'b0;
    res.camera          = '0;
    if (camera_enable) begin
      if (dz_val[DZ_CAM_POS] != 7'd0) begin
        cam_m = camera_curve(dz_val[DZ_CAM_POS]);
        res.camera_active = 1'b1;
        res.camera        = 16'(cam_m);
      end else if (dz_val[DZ_CAM_NEG] != 7'd0) begin
        cam_m = camera_curve(dz_val[DZ_CAM_NEG]);
        res.camera_active = 1'b1;
        res.camera        = -16'(cam_m);
      end else begin
        cam_m = '0;
      end
    end else begin
      cam_m = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
      out_data  <= res;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end
endmodule

// File: rtl/core/stick_deadzone_expo_mapper_unit.sv
// stick deadzone and expo mapper
// in channel: in_valid / in_stall carry one sample_t (four stick bytes,
//   centre 128); a transfer happens when in_valid is high and in_stall low
// out channel: out_valid / out_stall carry one result_t per sample
// path from input transfer to out_valid: the steering products are formed,
//   the divider is started, then five pedal/camera deadzone divides run one
//   bit a cycle (a single step for an axis that reads zero or full) beside
//   the 48-step steering divider; the slower of the two decides when the result is ready
// the block works on one sample at a time
// the block takes the next sample only after the result is loaded into the
//   output register; while out_stall is high the result holds, and a sample
//   taken meanwhile waits in the done state until out_stall is low
// configuration: apb writes at byte address 4*i, reads return the value
// reset restores register defaults and clears the right-stick-seen flag;
//   throttle and brake stay zero until a sample has a non-zero right stick
module stick_deadzone_expo_mapper_unit #(
  parameter int STEER_FULL_SCALE = 8192
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  sdem_pkg::sample_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sdem_pkg::result_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import sdem_pkg::*;

  logic [6:0] expo_percent, steer_edge, steer_center_zone, outer_zone, inner_zone;
  logic       swap_axes, camera_enable;
  logic       wr;
  logic [2:0] ridx;
  cmd_t       cmd;
  status_t    status;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      expo_percent      <= 7'd95;
      steer_edge        <= 7'd127;
      steer_center_zone <= 7'd6;
      outer_zone        <= 7'd114;
      inner_zone        <= 7'd10;
      swap_axes         <= 1'b0;
      camera_enable     <= 1'b0;
    end else if (wr) begin
      unique case (ridx)
        REG_EXPO:   expo_percent      <= pwdata[6:0];
        REG_EDGE:   steer_edge        <= pwdata[6:0];
        REG_CENTER: steer_center_zone <= pwdata[6:0];
        REG_OUTER:  outer_zone        <= pwdata[6:0];
        REG_INNER:  inner_zone        <= pwdata[6:0];
        REG_SWAP:   swap_axes         <= pwdata[0];
        REG_CAM:    camera_enable     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (ridx)
      REG_EXPO:   prdata = 32'(expo_percent);
      REG_EDGE:   prdata = 32'(steer_edge);
      REG_CENTER: prdata = 32'(steer_center_zone);
      REG_OUTER:  prdata = 32'(outer_zone);
      REG_INNER:  prdata = 32'(inner_zone);
      REG_SWAP:   prdata = 32'(swap_axes);
      REG_CAM:    prdata = 32'(camera_enable);
      default:    prdata = '0;
    endcase
  end

  sdem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  sdem_datapath #(.STEER_FULL_SCALE(STEER_FULL_SCALE)) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .in_data           (in_data),
    .expo_percent      (expo_percent),
    .steer_edge        (steer_edge),
    .steer_center_zone (steer_center_zone),
    .outer_zone        (outer_zone),
    .inner_zone        (inner_zone),
    .swap_axes         (swap_axes),
    .camera_enable     (camera_enable),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_data          (out_data)
  );

`ifndef SYNTHESIS
  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("accepted while busy");
  a_out_after_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid) else $error("result not shown");
  a_brake_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.brake_active) |-> out_data.brake == 13'd0)
    else $error("brake without active");
`endif
endmodule
